// ===== rtl/lbc_pkg.sv =====
// Shared types and constants for the block address to cylinder/head/sector converter.
package lbc_pkg;

	localparam int CYL_W   = 10;
	localparam int HEAD_W  = 8;
	localparam int SECT_W  = 6;
	localparam int DRIVE_W = 8;
	localparam int WORD_W  = 16;
	localparam int BYTE_W  = 8;
	// heads * sectors per track tops out at 255 * 63
	localparam int PER_CYL_W = HEAD_W + SECT_W;

	localparam logic [CYL_W-1:0] CYL_MAX = 10'd1023;

	localparam logic [SECT_W-1:0]  SPT_RESET   = 6'd18;
	localparam logic [HEAD_W-1:0]  HEADS_RESET = 8'd2;
	localparam logic [DRIVE_W-1:0] DRIVE_RESET = 8'h80;

	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	localparam logic [1:0] REG_SPT   = 2'd0;
	localparam logic [1:0] REG_HEADS = 2'd1;
	localparam logic [1:0] REG_DRIVE = 2'd2;

	typedef struct packed {
		logic [SECT_W-1:0]  spt;
		logic [HEAD_W-1:0]  heads;
		logic [DRIVE_W-1:0] drive;
	} cfg_t;

	typedef struct packed {
		logic [CYL_W-1:0]  cylinder;
		logic [HEAD_W-1:0] head;
		logic [SECT_W-1:0] sector;
		logic [WORD_W-1:0] cyl_sector_word;
		logic [WORD_W-1:0] head_drive_word;
		logic              out_of_range;
	} result_t;

endpackage

// ===== rtl/lbc_div_cell.sv =====
// One restoring-division cell: takes one dividend bit, yields one quotient bit.
module lbc_div_cell #(
	parameter int DIV_W  = 14,
	parameter int NUM_W  = 32,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [DIV_W-1:0]  divisor,
	input  logic              in_valid,
	input  logic [DIV_W-1:0]  in_rem,
	input  logic [NUM_W-1:0]  in_num,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [DIV_W-1:0]  out_rem,
	output logic [NUM_W-1:0]  out_num,
	output logic [SIDE_W-1:0] out_side
);

	logic [DIV_W:0]    trial;
	logic [DIV_W:0]    diff;
	logic              fits;
	logic              valid_s1;
	logic [DIV_W-1:0]  rem_s1;
	logic [NUM_W-1:0]  num_s1;
	logic [SIDE_W-1:0] side_s1;

	assign trial = {in_rem, in_num[NUM_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	// dividend bits leave at the top while quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		rem_s1  <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		num_s1  <= {in_num[NUM_W-2:0], fits};
		side_s1 <= in_side;
	end

	assign out_valid = valid_s1;
	assign out_rem   = rem_s1;
	assign out_num   = num_s1;
	assign out_side  = side_s1;

endmodule

// ===== rtl/lbc_pack.sv =====
// Output stage: applies saturation and zero-geometry rules, packs the service words.
module lbc_pack
	import lbc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 in_valid,
	input  logic                 in_ovf,
	input  logic [CYL_W-1:0]     in_cyl,
	input  logic [PER_CYL_W-1:0] in_quot,
	input  logic [SECT_W-1:0]    in_rem,
	output logic                 out_valid,
	output result_t              out_res
);

	logic              zero_geom;
	logic [CYL_W-1:0]  cyl;
	logic [HEAD_W-1:0] head;
	logic [SECT_W-1:0] sect;
	result_t           res;
	logic              valid_q;
	result_t           res_q;

	assign zero_geom = (cfg.spt == '0) || (cfg.heads == '0);

	always_comb begin
		if (zero_geom) begin
			cyl  = '0;
			head = '0;
			sect = '0;
		end else begin
			cyl  = in_ovf ? CYL_MAX : in_cyl;
			head = in_quot[HEAD_W-1:0];
			sect = in_rem + SECT_W'(1);
		end
		res.cylinder        = cyl;
		res.head            = head;
		res.sector          = sect;
		res.cyl_sector_word = {cyl[BYTE_W-1:0], cyl[CYL_W-1:BYTE_W], sect};
		res.head_drive_word = {head, cfg.drive};
		res.out_of_range    = zero_geom | in_ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res;
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule

// ===== rtl/lba_to_chs_convert_core.sv =====
// Top level of the block address to cylinder/head/sector converter.
//
// Usage:
//   Raise start with block_address; the request is taken at every edge where
//   start is high, and busy stays low, so a new address may come every cycle.
//   Each result appears for one cycle with done high, in request order.
//   The pipeline holds one cell per quotient bit of the cylinder division
//   (ADDRESS_WIDTH cells), one cell per bit of the 14-bit remainder for the
//   head/sector division, and the output register. Throughput is one address
//   per cycle. Geometry and drive number are set over the APB port (sectors
//   per track at 0x0, head count at 0x4, drive number at 0x8); the user must
//   write them only while no request is in flight, which the block does not
//   enforce. Reset clears all in-flight requests and loads 18 sectors,
//   2 heads, drive 0x80. The receiver cannot stall; done is never held off.
//   A cylinder past 1023 saturates and sets out_of_range; a zero head count or
//   sector count gives zero fields with out_of_range set.
module lba_to_chs_convert_core
	import lbc_pkg::*;
#(
	parameter int ADDRESS_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_ADDR_W-1:0]    paddr,
	input  logic [CFG_DATA_W-1:0]    pwdata,
	output logic [CFG_DATA_W-1:0]    prdata,
	output logic                     pready,
	input  logic                     start,
	output logic                     busy,
	input  logic [ADDRESS_WIDTH-1:0] block_address,
	output logic                     done,
	output logic [CYL_W-1:0]         cylinder,
	output logic [HEAD_W-1:0]        head,
	output logic [SECT_W-1:0]        sector,
	output logic [WORD_W-1:0]        cyl_sector_word,
	output logic [WORD_W-1:0]        head_drive_word,
	output logic                     out_of_range
);

	localparam int AW    = ADDRESS_WIDTH;
	localparam int SIDE2 = CYL_W + 1;

	cfg_t                 cfg_q;
	logic [1:0]           reg_idx;
	logic                 wr_en;
	logic [PER_CYL_W-1:0] per_cyl;

	logic                 c1_valid [0:AW];
	logic [PER_CYL_W-1:0] c1_rem   [0:AW];
	logic [AW-1:0]        c1_num   [0:AW];
	logic                 ovf_in   [0:AW-1];
	logic                 ovf_out  [1:AW];

	logic                 c2_valid [0:PER_CYL_W];
	logic [SECT_W-1:0]    c2_rem   [0:PER_CYL_W];
	logic [PER_CYL_W-1:0] c2_num   [0:PER_CYL_W];
	logic [SIDE2-1:0]     c2_side  [0:PER_CYL_W];

	result_t              res;

	// configuration registers
	assign reg_idx = paddr[CFG_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spt   <= SPT_RESET;
			cfg_q.heads <= HEADS_RESET;
			cfg_q.drive <= DRIVE_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SPT:   cfg_q.spt   <= pwdata[SECT_W-1:0];
				REG_HEADS: cfg_q.heads <= pwdata[HEAD_W-1:0];
				REG_DRIVE: cfg_q.drive <= pwdata[DRIVE_W-1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SPT:   prdata = {{(CFG_DATA_W-SECT_W){1'b0}}, cfg_q.spt};
			REG_HEADS: prdata = {{(CFG_DATA_W-HEAD_W){1'b0}}, cfg_q.heads};
			REG_DRIVE: prdata = {{(CFG_DATA_W-DRIVE_W){1'b0}}, cfg_q.drive};
			default:   prdata = '0;
		endcase
	end

	assign per_cyl = cfg_q.heads * cfg_q.spt;
	assign busy    = 1'b0;

	// cylinder division: address / (heads * sectors per track)
	assign c1_valid[0] = start && !busy;
	assign c1_rem[0]   = '0;
	assign c1_num[0]   = block_address;

	for (genvar k = 0; k < AW; k++) begin : g_cyl
		// fold each quotient bit at or above the cylinder width into the sticky flag
		if (k == 0) begin : g_first
			assign ovf_in[k] = 1'b0;
		end else if ((AW - k) >= CYL_W) begin : g_high
			assign ovf_in[k] = ovf_out[k] | c1_num[k][0];
		end else begin : g_low
			assign ovf_in[k] = ovf_out[k];
		end

		lbc_div_cell #(
			.DIV_W  (PER_CYL_W),
			.NUM_W  (AW),
			.SIDE_W (1)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.divisor   (per_cyl),
			.in_valid  (c1_valid[k]),
			.in_rem    (c1_rem[k]),
			.in_num    (c1_num[k]),
			.in_side   (ovf_in[k]),
			.out_valid (c1_valid[k+1]),
			.out_rem   (c1_rem[k+1]),
			.out_num   (c1_num[k+1]),
			.out_side  (ovf_out[k+1])
		);
	end

	// head/sector division: remainder / sectors per track
	assign c2_valid[0] = c1_valid[AW];
	assign c2_rem[0]   = '0;
	assign c2_num[0]   = c1_rem[AW];
	assign c2_side[0]  = {ovf_out[AW], c1_num[AW][CYL_W-1:0]};

	for (genvar j = 0; j < PER_CYL_W; j++) begin : g_hs
		lbc_div_cell #(
			.DIV_W  (SECT_W),
			.NUM_W  (PER_CYL_W),
			.SIDE_W (SIDE2)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.divisor   (cfg_q.spt),
			.in_valid  (c2_valid[j]),
			.in_rem    (c2_rem[j]),
			.in_num    (c2_num[j]),
			.in_side   (c2_side[j]),
			.out_valid (c2_valid[j+1]),
			.out_rem   (c2_rem[j+1]),
			.out_num   (c2_num[j+1]),
			.out_side  (c2_side[j+1])
		);
	end

	lbc_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (c2_valid[PER_CYL_W]),
		.in_ovf    (c2_side[PER_CYL_W][CYL_W]),
		.in_cyl    (c2_side[PER_CYL_W][CYL_W-1:0]),
		.in_quot   (c2_num[PER_CYL_W]),
		.in_rem    (c2_rem[PER_CYL_W]),
		.out_valid (done),
		.out_res   (res)
	);

	assign cylinder        = res.cylinder;
	assign head            = res.head;
	assign sector          = res.sector;
	assign cyl_sector_word = res.cyl_sector_word;
	assign head_drive_word = res.head_drive_word;
	assign out_of_range    = res.out_of_range;

endmodule
